### rtl/lst_pkg.sv
// Shared types and constants for the positional list block.
// Used by the channel interfaces, the step unit, the entry memory and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

  // list capacity and field widths
  localparam int CAPACITY = 16;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_DUMP    = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // step unit operations
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_INC  = 2'd1,
    OP_DEC  = 2'd2
  } step_op_t;

  // step unit results
  typedef struct packed {
    pos_t sum;
    logic a_lt_b;
    logic sum_lt_b;
    logic sum_eq_b;
  } step_res_t;

endpackage

`default_nettype wire

### rtl/lst_in_if.sv
// Request channel: valid/ready handshake with request type, position and value.
// Depends on lst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lst_in_if;
  import lst_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  pos_t             position;
  data_t            value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

`default_nettype wire

### rtl/lst_out_if.sv
// Result channel: valid/ready handshake with status, item, last flag and length.
// Depends on lst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lst_out_if;
  import lst_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  data_t             item;
  logic              last;
  pos_t              length;

  modport source (output valid, status, item, last, length, input ready);
  modport sink   (input valid, status, item, last, length, output ready);
endinterface

`default_nettype wire

### rtl/lst_step.sv
// Shared index unit: one add of -1/0/+1 and the compares against a bound.
// Depends on lst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lst_step (
  input  lst_pkg::pos_t      a,
  input  lst_pkg::pos_t      b,
  input  lst_pkg::step_op_t  op,
  output lst_pkg::step_res_t res
);
  import lst_pkg::*;

  pos_t sum;

  // increment / decrement / pass
  always_comb begin
    unique case (op)
      OP_INC:  sum = a + pos_t'(1);
      OP_DEC:  sum = a - pos_t'(1);
      OP_PASS: sum = a;
      default: sum = a;
    endcase
  end

  // compares against the bound
  always_comb begin
    res.sum      = sum;
    res.a_lt_b   = (a < b);
    res.sum_lt_b = (sum < b);
    res.sum_eq_b = (sum == b);
  end

endmodule

`default_nettype wire

### rtl/lst_mem.sv
// Entry storage: one write port and one read port with registered read data.
// Depends on lst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lst_mem (
  input  logic           clk,
  input  logic           wr_en,
  input  lst_pkg::addr_t wr_addr,
  input  lst_pkg::data_t wr_data,
  input  logic           rd_en,
  input  lst_pkg::addr_t rd_addr,
  output lst_pkg::data_t rd_data
);
  import lst_pkg::*;

  data_t mem_r [CAPACITY];
  data_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/positional_list_insert_delete_top.sv
// Positional list top level: request sequencer, result register, step unit and entry memory.
// Depends on lst_pkg, lst_in_if, lst_out_if, lst_step and lst_mem.
//
// Usage:
//   in_ch carries requests (insert at a 1-based position, delete at a position,
//   dump all entries). A request is taken on a transfer (valid and ready high).
//   out_ch carries results: status, item, last and the list length afterwards.
//   Insert and delete give one result; a dump gives one result per entry (or one
//   EMPTY result), with last set on the final one. Errors give one result.
// Sequence: each request is classified first; an error or unknown request then
//   loads its result. Insert shifts entries up from the tail to the position and
//   writes the value; delete reads the victim and pulls later entries down; dump
//   reads each entry in turn and hands it out.
//   Each moved entry is read and then written back on the entry
//   memory, sequenced through the shared index unit.
// One request is worked at a time: in_ch.ready is high only while idle. A new
// request can be taken while the previous final result still waits in the
// output register.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// Stalls on out_ch hold the result register and pause the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete_top (
  input  logic     clk,
  input  logic     rst_n,
  lst_in_if.sink   in_ch,
  lst_out_if.source out_ch
);
  import lst_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CHK   = 13'b0000000000010,
    S_ITST  = 13'b0000000000100,
    S_SWR   = 13'b0000000001000,
    S_PUT   = 13'b0000000010000,
    S_DGET  = 13'b0000000100000,
    S_DGOT  = 13'b0000001000000,
    S_DTST  = 13'b0000010000000,
    S_DWR   = 13'b0000100000000,
    S_DFIN  = 13'b0001000000000,
    S_PRD   = 13'b0010000000000,
    S_PWAIT = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  state_t    state_r, state_nxt;
  req_t      kind_r, kind_nxt;
  pos_t      pos_r, pos_nxt;
  data_t     val_r, val_nxt;
  cnt_t      idx_r, idx_nxt;
  cnt_t      count_r, count_nxt;
  status_t   res_status_r, res_status_nxt;
  data_t     res_item_r, res_item_nxt;

  logic      out_valid_r;
  status_t   out_status_r;
  data_t     out_item_r;
  logic      out_last_r;
  pos_t      out_length_r;

  logic      out_load;
  logic      out_free;
  status_t   load_status;
  data_t     load_item;
  logic      load_last;

  pos_t      step_a, step_b;
  step_op_t  step_op;
  step_res_t step;

  logic      mem_wr_en, mem_rd_en;
  addr_t     mem_wr_addr, mem_rd_addr;
  data_t     mem_wr_data, mem_rd_data;

  lst_step u_step (
    .a   (step_a),
    .b   (step_b),
    .op  (step_op),
    .res (step)
  );

  lst_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_item_nxt   = res_item_r;
    step_a         = pos_t'(idx_r);
    step_b         = pos_r;
    step_op        = OP_PASS;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = idx_r[ADDR_W-1:0];
    mem_wr_data    = mem_rd_data;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = step.sum[ADDR_W-1:0];
    out_load       = 1'b0;
    load_status    = res_status_r;
    load_item      = res_item_r;
    load_last      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = req_t'(in_ch.req_type);
          pos_nxt   = in_ch.position;
          val_nxt   = in_ch.value;
          state_nxt = S_CHK;
        end
      end

      // classify the request and catch the error cases
      S_CHK: begin
        res_item_nxt = '0;
        unique case (kind_r)
          REQ_INSERT: begin
            step_a  = pos_t'(count_r);
            step_op = OP_INC;
            if (count_r == CAP_CNT) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_EMIT;
            end else if (pos_r == '0 || step.sum_lt_b) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_EMIT;
            end else begin
              idx_nxt   = count_r;
              state_nxt = S_ITST;
            end
          end
          REQ_DELETE: begin
            step_a = pos_t'(count_r);
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else if (pos_r == '0 || step.a_lt_b) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_DGET;
            end
          end
          REQ_DUMP: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_PRD;
            end
          end
          default: begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_EMIT;
          end
        endcase
      end

      // insert: shift entries up while idx >= pos, reading idx-1
      S_ITST: begin
        step_op = OP_DEC;
        if (step.a_lt_b) begin
          state_nxt = S_PUT;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = S_SWR;
        end
      end

      S_SWR: begin
        step_op   = OP_DEC;
        mem_wr_en = 1'b1;
        idx_nxt   = step.sum[CNT_W-1:0];
        state_nxt = S_ITST;
      end

      // idx has landed on pos-1
      S_PUT: begin
        step_a         = pos_t'(count_r);
        step_op        = OP_INC;
        mem_wr_en      = 1'b1;
        mem_wr_data    = val_r;
        count_nxt      = step.sum[CNT_W-1:0];
        res_status_nxt = ST_OK;
        state_nxt      = S_EMIT;
      end

      // delete: read the victim at pos-1
      S_DGET: begin
        step_a    = pos_r;
        step_op   = OP_DEC;
        idx_nxt   = step.sum[CNT_W-1:0];
        mem_rd_en = 1'b1;
        state_nxt = S_DGOT;
      end

      // capture the victim, then pull entries down while idx+1 < count
      S_DGOT, S_DTST: begin
        if (state_r == S_DGOT) begin
          res_item_nxt = mem_rd_data;
        end
        step_b  = pos_t'(count_r);
        step_op = OP_INC;
        if (step.sum_lt_b) begin
          mem_rd_en = 1'b1;
          state_nxt = S_DWR;
        end else begin
          state_nxt = S_DFIN;
        end
      end

      S_DWR: begin
        step_op   = OP_INC;
        mem_wr_en = 1'b1;
        idx_nxt   = step.sum[CNT_W-1:0];
        state_nxt = S_DTST;
      end

      S_DFIN: begin
        step_a         = pos_t'(count_r);
        step_op        = OP_DEC;
        count_nxt      = step.sum[CNT_W-1:0];
        res_status_nxt = ST_OK;
        state_nxt      = S_EMIT;
      end

      // dump: read one entry, then hand it out
      S_PRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = idx_r[ADDR_W-1:0];
        state_nxt   = S_PWAIT;
      end

      S_PWAIT: begin
        step_b  = pos_t'(count_r);
        step_op = OP_INC;
        if (out_free) begin
          out_load    = 1'b1;
          load_status = ST_OK;
          load_item   = mem_rd_data;
          load_last   = step.sum_eq_b;
          idx_nxt     = step.sum[CNT_W-1:0];
          state_nxt   = step.sum_eq_b ? S_IDLE : S_PRD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_item_r   <= res_item_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= load_status;
      out_item_r   <= load_item;
      out_last_r   <= load_last;
      out_length_r <= pos_t'(count_r);
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.item   = out_item_r;
  assign out_ch.last   = out_last_r;
  assign out_ch.length = out_length_r;

  // list length moves by at most one per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == cnt_t'($past(count_r) + 1'b1) || count_r == cnt_t'($past(count_r) - 1'b1)))
    else $error("list length jumped");

  // length changes only when an insert or delete completes
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(state_r) == S_PUT || $past(state_r) == S_DFIN))
    else $error("list length changed outside insert/delete completion");

  // a result that is not the last one is always a good dump entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (out_ch.status == ST_OK))
    else $error("non-final result carries an error status");

  // the entry memory is never written while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r != S_IDLE && !in_ch.ready))
    else $error("memory write while idle");

  // no result is loaded over one that has not been taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_valid_r) |-> out_ch.ready)
    else $error("result register overwritten");

endmodule

`default_nettype wire

### test/list_checker.sv
// Scoreboard for the positional list: tracks the list contents from the request channel,
// predicts every result and compares it with what appears on the result channel.
// Depends on lst_pkg, lst_in_if and lst_out_if.
`timescale 1ns / 1ps

module list_checker (
  input  logic clk,
  input  logic rst_n,
  lst_in_if    in_ch,
  lst_out_if   out_ch,
  output int   mismatch_count,
  output int   results_owed,
  output int   list_length
);
  import lst_pkg::*;

  typedef struct packed {
    status_t status;
    data_t   item;
    logic    last;
    pos_t    length;
  } list_result_t;

  // shadow copy of the list, head first
  data_t        shadow_list[$];
  // results predicted but not yet seen, oldest first
  list_result_t owed_results[$];

  task automatic owe_result(input status_t status, input data_t item, input logic last);
    list_result_t r;
    r.status = status;
    r.item   = item;
    r.last   = last;
    r.length = pos_t'(shadow_list.size());
    owed_results.push_back(r);
  endtask

  // Apply one request to the shadow list and queue the results it causes.
  task automatic apply_request(input req_t kind, input pos_t pos, input data_t val);
    int    n;
    int    p;
    data_t taken;
    n = shadow_list.size();
    p = int'(pos);
    case (kind)
      REQ_INSERT: begin
        if (n >= CAPACITY) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else if (p < 1 || p > n + 1) begin
          owe_result(ST_RANGE, '0, 1'b1);
        end else begin
          shadow_list.insert(p - 1, val);
          owe_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (n == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else if (p < 1 || p > n) begin
          owe_result(ST_RANGE, '0, 1'b1);
        end else begin
          taken = shadow_list[p - 1];
          shadow_list.delete(p - 1);
          owe_result(ST_OK, taken, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (n == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            owe_result(ST_OK, shadow_list[i], i == n - 1);
        end
      end
      default: begin
        // unknown request: flagged as out of range, list untouched
        owe_result(ST_RANGE, '0, 1'b1);
      end
    endcase
  endtask

  // Compare one result transfer against the oldest prediction.
  task automatic check_result();
    list_result_t got;
    list_result_t want;
    got.status = status_t'(out_ch.status);
    got.item   = out_ch.item;
    got.last   = out_ch.last;
    got.length = out_ch.length;
    if (owed_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result: status=%0d item=%0d last=%0d length=%0d",
               $time, got.status, got.item, got.last, got.length);
    end else begin
      want = owed_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        $display("%0t: result mismatch: expected status=%0d item=%0d last=%0d length=%0d,%s",
                 $time, want.status, want.item, want.last, want.length,
                 $sformatf(" got status=%0d item=%0d last=%0d length=%0d",
                           got.status, got.item, got.last, got.length));
      end
    end
  endtask

  // Requests are applied before results so both can transfer in one cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_list.delete();
      owed_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        apply_request(req_t'(in_ch.req_type), in_ch.position, in_ch.value);
      if (out_ch.valid && out_ch.ready)
        check_result();
    end
    results_owed = owed_results.size();
    list_length  = shadow_list.size();
  end

endmodule

### test/tb.sv
// Top of the positional list testbench: clock, reset, request stimulus, result-side stalls
// and the verdict. Depends on lst_pkg, lst_in_if, lst_out_if, list_checker and the block.
`timescale 1ns / 1ps

module tb;
  import lst_pkg::*;

  typedef enum {GROW, SHRINK, CHURN} list_phase_t;
  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} stall_mode_t;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   results_owed;
  int   list_length;

  lst_in_if  req_ch();
  lst_out_if res_ch();

  positional_list_insert_delete_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  list_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (req_ch),
    .out_ch         (res_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .list_length    (list_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input req_t kind, input int pos, input data_t val);
    req_ch.valid    = 1'b1;
    req_ch.req_type = kind;
    req_ch.position = pos_t'(pos);
    req_ch.value    = val;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // Sender waits until every predicted result has come back.
  task automatic drain_results();
    req_ch.valid = 1'b0;
    wait (results_owed == 0);
    @(negedge clk);
  endtask

  // Request stimulus
  initial begin
    int          n;
    int          pos;
    int          roll;
    int          burst_left;
    int          phase_left;
    list_phase_t phase;
    req_t        kind;
    data_t       val;

    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty list cases, bad positions, extremes, full list, head/tail
    send_request(REQ_DUMP, 0, '0);
    send_request(REQ_DELETE, 0, '0);          // empty wins over bad position
    send_request(REQ_INSERT, 0, '0);
    send_request(REQ_INSERT, 2, '0);
    send_request(REQ_INSERT, 1, 32'sh8000_0000);
    send_request(REQ_INSERT, 2, 32'sh7FFF_FFFF);   // at tail
    send_request(REQ_INSERT, 1, -32'sd1);          // at head
    send_request(REQ_INSERT, 2, '0);               // in the middle
    repeat (CAPACITY - 4)
      send_request(REQ_INSERT, $urandom_range(1, list_length + 1), data_t'($urandom));
    send_request(REQ_INSERT, 0, '1);          // full wins over bad position
    send_request(REQ_DUMP, 0, '0);
    send_request(REQ_DELETE, CAPACITY + 1, '0);
    send_request(REQ_DELETE, CAPACITY, '0);   // tail
    send_request(REQ_DELETE, 1, '0);          // head
    send_request(REQ_UNKNOWN, 127, '1);
    drain_results();

    // random: phases that grow, shrink or churn the list, sent in bursts
    burst_left = 0;
    phase_left = 0;
    phase      = CHURN;
    for (int i = 0; i < 420; i++) begin
      if (phase_left == 0) begin
        phase      = list_phase_t'($urandom_range(2));
        phase_left = $urandom_range(15, 45);
        if ($urandom_range(2) == 0)
          drain_results();
      end
      phase_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        hold_off(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
      end
      burst_left--;

      val = data_t'($urandom);
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       val = 32'sh8000_0000;
          1:       val = 32'sh7FFF_FFFF;
          2:       val = '0;
          default: val = '1;
        endcase
      end

      n    = list_length;
      roll = $urandom_range(99);
      if (roll < 8) begin
        // noise: any type, any position
        kind = req_t'($urandom_range(3));
        pos  = $urandom_range(127);
      end else begin
        roll = $urandom_range(99);
        case (phase)
          GROW:    kind = (roll < 70) ? REQ_INSERT : (roll < 88) ? REQ_DELETE : REQ_DUMP;
          SHRINK:  kind = (roll < 70) ? REQ_DELETE : (roll < 88) ? REQ_INSERT : REQ_DUMP;
          default: kind = (roll < 42) ? REQ_INSERT : (roll < 84) ? REQ_DELETE : REQ_DUMP;
        endcase
        // legal position, biased toward head and tail
        pos = (kind == REQ_INSERT) ? n + 1 : ((n == 0) ? 1 : n);
        case ($urandom_range(3))
          0:       pos = 1;
          1:       ;
          default: pos = $urandom_range(1, pos);
        endcase
      end
      send_request(kind, pos, val);
    end

    req_ch.valid = 1'b0;
    wait (results_owed == 0);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Result-side back-pressure, switching among random stall patterns
  initial begin
    stall_mode_t mode;
    int          span;
    int          cyc;

    res_ch.ready = 1'b0;
    cyc = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(3));
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk);
        cyc++;
        case (mode)
          RX_OPEN:     res_ch.ready = 1'b1;
          RX_COIN:     res_ch.ready = $urandom_range(1);
          RX_PERIODIC: res_ch.ready = (cyc % 3 == 0);
          default:     res_ch.ready = ($urandom_range(9) == 0);
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
